// File: design/tkas_pkg.sv
// tkas_pkg: shared constants, item types and snapshot type for the top-k altitude selector
// no dependencies
`timescale 1ns / 1ps

package tkas_pkg;

    localparam int TOP_COUNT = 3;
    localparam int STAMP_W   = 16;
    localparam int ALT_W     = 12;
    localparam int HEIGHT_W  = ALT_W - 1;
    localparam int RANK_W    = 3;
    localparam int IDX_W     = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOP_COUNT - 1);

    typedef struct packed {
        logic [STAMP_W-1:0]      stamp;
        logic signed [ALT_W-1:0] altitude;
        logic                    set_end;
    } t_in_item;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [STAMP_W-1:0] best_stamp;
        logic               final_res;
    } t_out_item;

    typedef logic [TOP_COUNT-1:0][STAMP_W-1:0] t_snap;

    typedef struct packed {
        logic     step;
        t_in_item rec;
    } t_store_cmd;

endpackage

// File: design/top_k_altitude_selector_unit.sv
// top_k_altitude_selector_unit: input register, ranked store and result sender
// depends on tkas_pkg, tkas_store, tkas_emit
// flow: an accepted item waits in the input register, then is ranked in the store;
// a set end passes the ranking to the result sender, which sends it in rank order
// throughput: one item per cycle unless o_stall is raised; a set-end item holds the
// result sender until its TOP_COUNT results are taken, so a second set end stalls meanwhile
// reset: synchronous active low, empties input register, store and result sender
`timescale 1ns / 1ps

module top_k_altitude_selector_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tkas_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output tkas_pkg::t_out_item o_result
);
    import tkas_pkg::*;

    logic       r_in_valid;
    logic       n_in_valid;
    t_in_item   r_in;
    logic       can_load;
    logic       proceed;
    logic       in_take;
    t_store_cmd cmd;
    t_snap      snap;

    assign proceed  = !r_in.set_end || can_load;
    assign o_stall  = r_in_valid && !proceed;
    assign in_take  = i_valid && !o_stall;
    assign cmd.step = r_in_valid && proceed;
    assign cmd.rec  = r_in;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (cmd.step) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_item;
        end
    end

    tkas_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_snap  (snap)
    );

    tkas_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (cmd.step && r_in.set_end),
        .i_snap     (snap),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result)
    );

endmodule

// File: design/tkas_store.sv
// tkas_store: ranked store of the highest records with combinational compare and insert
// depends on tkas_pkg
`timescale 1ns / 1ps

module tkas_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tkas_pkg::t_store_cmd i_cmd,
    output tkas_pkg::t_snap     o_snap
);
    import tkas_pkg::*;

    logic [STAMP_W-1:0]  r_stamp  [TOP_COUNT];
    logic [HEIGHT_W-1:0] r_height [TOP_COUNT];
    logic [TOP_COUNT-1:0] r_valid;

    logic [STAMP_W-1:0]  ins_stamp  [TOP_COUNT];
    logic [HEIGHT_W-1:0] ins_height [TOP_COUNT];
    logic [TOP_COUNT-1:0] ins_valid;
    logic [TOP_COUNT-1:0] beat;
    logic [HEIGHT_W-1:0]  height;

    // negative altitude counts as zero
    assign height = i_cmd.rec.altitude[ALT_W-1] ? '0 : i_cmd.rec.altitude[HEIGHT_W-1:0];

    // valid entries form a prefix with nonincreasing heights, so beat is monotone
    always_comb begin
        for (int i = 0; i < TOP_COUNT; i++) begin
            beat[i] = !r_valid[i] || (height > r_height[i]);
        end
        for (int i = 0; i < TOP_COUNT; i++) begin
            if (i > 0 && beat[(i > 0) ? i - 1 : 0]) begin
                ins_stamp[i]  = r_stamp[(i > 0) ? i - 1 : 0];
                ins_height[i] = r_height[(i > 0) ? i - 1 : 0];
                ins_valid[i]  = r_valid[(i > 0) ? i - 1 : 0];
            end else if (beat[i]) begin
                ins_stamp[i]  = i_cmd.rec.stamp;
                ins_height[i] = height;
                ins_valid[i]  = 1'b1;
            end else begin
                ins_stamp[i]  = r_stamp[i];
                ins_height[i] = r_height[i];
                ins_valid[i]  = r_valid[i];
            end
            o_snap[i] = ins_valid[i] ? ins_stamp[i] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.step) begin
            r_valid <= i_cmd.rec.set_end ? '0 : ins_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            for (int i = 0; i < TOP_COUNT; i++) begin
                r_stamp[i]  <= ins_stamp[i];
                r_height[i] <= ins_height[i];
            end
        end
    end

`ifndef SYNTH
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[0] |-> r_valid == '0)
        else $error("store valid bits not a prefix");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && i_cmd.rec.set_end) |=> r_valid == '0)
        else $error("store not cleared after set end");
    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !i_cmd.rec.set_end) |=> r_valid[0])
        else $error("store empty after a record");
`endif

endmodule

// File: design/tkas_emit.sv
// tkas_emit: holds the ranking snapshot of a finished set and sends one result item per rank
// depends on tkas_pkg
`timescale 1ns / 1ps

module tkas_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  tkas_pkg::t_snap     i_snap,
    output logic                o_can_load,
    output logic                o_valid,
    input  logic                i_stall,
    output tkas_pkg::t_out_item o_result
);
    import tkas_pkg::*;

    logic             r_busy;
    logic             n_busy;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    t_snap            r_snap;
    logic             out_take;

    assign out_take   = r_busy && !i_stall;
    assign o_can_load = !r_busy || (out_take && r_idx == LAST_IDX);

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (i_load) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (out_take) begin
            if (r_idx == LAST_IDX) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_snap <= i_snap;
        end
    end

    assign o_valid             = r_busy;
    assign o_result.rank       = RANK_W'(r_idx);
    assign o_result.best_stamp = r_snap[r_idx];
    assign o_result.final_res  = (r_idx == LAST_IDX);

`ifndef SYNTH
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= LAST_IDX)
        else $error("rank index past last slot");
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_busy && r_idx == '0)
        else $error("load did not restart at rank zero");
    a_load_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("snapshot loaded over a run in progress");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && r_idx == LAST_IDX && !i_load) |=> !r_busy)
        else $error("still busy after final item");
`endif

endmodule

// File: tb/tkas_altitude_checker.sv
// tkas_altitude_checker: watches both channels of the top-k altitude selector, keeps its own
// ranking of the current set and compares every result item with the expected ranking
// depends on tkas_pkg
`timescale 1ns / 1ps

module tkas_altitude_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  tkas_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  tkas_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending
);
    import tkas_pkg::*;

    logic [STAMP_W-1:0]  best_stamp_q  [TOP_COUNT];
    logic [HEIGHT_W-1:0] best_height_q [TOP_COUNT];
    logic                best_filled_q [TOP_COUNT];
    t_out_item           ranking_due [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    task automatic clear_ranking();
        for (int i = 0; i < TOP_COUNT; i++) begin
            best_stamp_q[i]  = '0;
            best_height_q[i] = '0;
            best_filled_q[i] = 1'b0;
        end
    endtask

    task automatic rank_record(input t_in_item rec);
        logic [HEIGHT_W-1:0] height;
        int                  slot;
        t_out_item           res;
        height = rec.altitude[ALT_W-1] ? '0 : rec.altitude[HEIGHT_W-1:0];
        slot = TOP_COUNT;
        // first slot that is empty or strictly lower wins, so ties keep the earlier record
        for (int i = TOP_COUNT - 1; i >= 0; i--) begin
            if (!best_filled_q[i] || height > best_height_q[i]) begin
                slot = i;
            end
        end
        if (slot < TOP_COUNT) begin
            for (int i = TOP_COUNT - 1; i > slot; i--) begin
                best_stamp_q[i]  = best_stamp_q[i-1];
                best_height_q[i] = best_height_q[i-1];
                best_filled_q[i] = best_filled_q[i-1];
            end
            best_stamp_q[slot]  = rec.stamp;
            best_height_q[slot] = height;
            best_filled_q[slot] = 1'b1;
        end
        if (rec.set_end) begin
            for (int i = 0; i < TOP_COUNT; i++) begin
                res.rank       = RANK_W'(i);
                res.best_stamp = best_filled_q[i] ? best_stamp_q[i] : '0;
                res.final_res  = (i == TOP_COUNT - 1);
                ranking_due.push_back(res);
            end
            clear_ranking();
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_out_item want;
        if (!i_rst_n) begin
            clear_ranking();
            ranking_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                rank_record(i_in_item);
            end
            if (i_out_valid && !i_out_stall) begin
                if (ranking_due.size() == 0) begin
                    report_mismatch("unexpected result, best_stamp",
                                    32'(i_out_item.best_stamp), 32'(0));
                end else begin
                    want = ranking_due.pop_front();
                    if (i_out_item.rank !== want.rank) begin
                        report_mismatch("rank", 32'(i_out_item.rank), 32'(want.rank));
                    end
                    if (i_out_item.best_stamp !== want.best_stamp) begin
                        report_mismatch("best_stamp", 32'(i_out_item.best_stamp),
                                        32'(want.best_stamp));
                    end
                    if (i_out_item.final_res !== want.final_res) begin
                        report_mismatch("final_res", 32'(i_out_item.final_res),
                                        32'(want.final_res));
                    end
                end
            end
        end
        o_pending <= ranking_due.size();
    end

endmodule

// File: tb/top_k_altitude_selector_unit_tb.sv
// top_k_altitude_selector_unit_tb: drives telemetry sets into the selector, stalls its
// result channel at random and gives the verdict from the checker's failure count
// depends on tkas_pkg, top_k_altitude_selector_unit, tkas_altitude_checker
`timescale 1ns / 1ps

module top_k_altitude_selector_unit_tb;
    import tkas_pkg::*;

    localparam int RANDOM_ITEMS = 210;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    t_in_item  i_item  = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_result;

    logic calm = 1'b0;
    int   fail_count;
    int   pending;
    int   stuck_cycles = 0;

    always #5 i_clk = ~i_clk;

    top_k_altitude_selector_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    tkas_altitude_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_item    (i_item),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_item   (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < 13);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_record(input logic [STAMP_W-1:0] stamp,
                               input logic signed [ALT_W-1:0] altitude, input logic last);
        while (!calm && $urandom_range(0, 99) < 13) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= '{stamp: stamp, altitude: altitude, set_end: last};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [ALT_W-1:0] pick_altitude(input int spread);
        case (spread)
            2:       return ALT_W'($urandom_range(0, 5)) - ALT_W'(2);
            3:       return ALT_W'($urandom_range(2040, 2047));
            default: return ALT_W'($urandom);
        endcase
    endfunction

    initial begin
        int sent;
        int set_size;
        int spread;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // extremes, negative clamp and a tie at the top
        send_record(16'h0000, 12'sd0, 1'b0);
        send_record(16'hFFFF, 12'sd2047, 1'b0);
        send_record(16'h1234, -12'sd1, 1'b0);
        send_record(16'h0001, -12'sd2048, 1'b0);
        send_record(16'h5555, 12'sd2047, 1'b0);
        send_record(16'hAAAA, 12'sd1, 1'b1);
        // single record set, two slots never filled
        send_record(16'h7777, -12'sd5, 1'b1);
        // all heights zero after clamping
        send_record(16'h0101, 12'sd0, 1'b0);
        send_record(16'h0202, -12'sd300, 1'b0);
        send_record(16'h0303, 12'sd0, 1'b1);
        // two records, one slot empty
        send_record(16'h0011, 12'sd100, 1'b0);
        send_record(16'h0022, 12'sd200, 1'b1);
        // rising heights push older entries out of a full store
        for (int k = 1; k <= 5; k++) begin
            send_record(16'(16'h0100 + k), 12'(k * 10), k == 5);
        end
        // back to back set ends
        send_record(16'h00AA, 12'sd5, 1'b1);
        send_record(16'h00BB, 12'sd6, 1'b1);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
            spread   = $urandom_range(0, 3);
            calm    <= (sent >= 80 && sent < 140);
            for (int k = 0; k < set_size; k++) begin
                send_record(16'($urandom), pick_altitude(spread), k == set_size - 1);
                sent++;
            end
        end
        i_valid <= 1'b0;
        calm    <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: top_k_altitude_selector_unit.f
design/tkas_pkg.sv
design/tkas_store.sv
design/tkas_emit.sv
design/top_k_altitude_selector_unit.sv
tb/tkas_altitude_checker.sv
tb/top_k_altitude_selector_unit_tb.sv
